// ===== design/dafd_pkg.sv =====
package dafd_pkg;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned HIST_W      = 24;
  localparam int unsigned PRED_W      = 22;
  localparam int unsigned ACC_W       = 33;
  localparam int unsigned PCM_W       = 16;
  localparam int unsigned COEF_W      = 7;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [ACC_W-1:0] PRED_MAX = 33'sd2097151;
  localparam logic signed [ACC_W-1:0] PRED_MIN = -33'sd2097152;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 33'sd32;
  localparam logic signed [17:0] PCM_MAX = 18'sd32767;
  localparam logic signed [17:0] PCM_MIN = -18'sd32768;

  typedef struct packed {
    logic signed [NIB_W-1:0] nibble;
    logic [3:0]              coef_idx;
    logic [3:0]              shift;
  } sample_req_t;

  function automatic logic [COEF_W-1:0] coef_first(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd1:    c = 7'd60;
      4'd2:    c = 7'd115;
      4'd3:    c = 7'd98;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

  function automatic logic [COEF_W-1:0] coef_second(input logic [3:0] idx);
    logic [COEF_W-1:0] c;
    case (idx)
      4'd2:    c = 7'd52;
      4'd3:    c = 7'd55;
      default: c = 7'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== design/dafd_byte_if.sv =====
interface dafd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== design/dafd_pcm_if.sv =====
interface dafd_pcm_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;

  modport source (output valid, output pcm_sample, input ready);
  modport sink (input valid, input pcm_sample, output ready);
endinterface

// ===== design/dafd_cfg_if.sv =====
interface dafd_cfg_if;
  logic valid;
  logic ready;
  logic channel_select;

  modport source (output valid, output channel_select, input ready);
  modport sink (input valid, input channel_select, output ready);
endinterface

// ===== design/dafd_front.sv =====
module dafd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  dafd_byte_if.sink             in_ch,
  dafd_cfg_if.sink              cfg_ch,
  input  logic                  q_full,
  output logic                  q_push,
  output dafd_pkg::sample_req_t q_data
);

  logic                         chan_r;
  logic [dafd_pkg::POS_W-1:0]   pos_r;
  logic [dafd_pkg::POS_W-1:0]   pos;
  logic [3:0]                   coef_r;
  logic [3:0]                   shift_r;
  logic                         accept;
  logic                         is_header;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && in_ch.ready;

  // frame_start forces this byte to position zero
  assign pos       = in_ch.frame_start ? '0 : pos_r;
  assign is_header = (pos < dafd_pkg::POS_W'(dafd_pkg::HDR_BYTES));

  assign q_push          = accept && !is_header;
  assign q_data.nibble   = chan_r ? in_ch.data_byte[7:4] : in_ch.data_byte[3:0];
  assign q_data.coef_idx = coef_r;
  assign q_data.shift    = shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= 1'b0;
      pos_r   <= '0;
      coef_r  <= '0;
      shift_r <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        chan_r <= cfg_ch.channel_select;
      end
      if (accept) begin
        pos_r <= pos + 1'b1;
        if (is_header && pos == {{(dafd_pkg::POS_W-1){1'b0}}, chan_r}) begin
          coef_r  <= in_ch.data_byte[7:4];
          shift_r <= in_ch.data_byte[3:0];
        end
      end
    end
  end

endmodule

// ===== design/dafd_queue.sv =====
module dafd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dafd_pkg::sample_req_t push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output dafd_pkg::sample_req_t head_data
);

  dafd_pkg::sample_req_t            mem_r [dafd_pkg::QUEUE_DEPTH];
  logic [dafd_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [dafd_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [dafd_pkg::QPTR_W:0]        count_r;
  logic [dafd_pkg::QPTR_W:0]        count_nxt;

  assign full       = (count_r == (dafd_pkg::QPTR_W+1)'(dafd_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/dafd_back.sv =====
module dafd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  dafd_pkg::sample_req_t q_data,
  output logic                  q_pop,
  dafd_pcm_if.source            out_ch
);

  logic signed [dafd_pkg::HIST_W-1:0] hist1_r;
  logic signed [dafd_pkg::HIST_W-1:0] hist2_r;
  logic signed [dafd_pkg::PCM_W-1:0]  pcm_r;
  logic signed [dafd_pkg::PCM_W-1:0]  pcm_nxt;
  logic                               valid_r;

  logic signed [dafd_pkg::COEF_W:0]   c1;
  logic signed [dafd_pkg::COEF_W:0]   c2;
  logic signed [dafd_pkg::ACC_W-1:0]  p1;
  logic signed [dafd_pkg::ACC_W-1:0]  p2;
  logic signed [dafd_pkg::ACC_W-1:0]  acc;
  logic signed [dafd_pkg::ACC_W-1:0]  pred_full;
  logic signed [dafd_pkg::PRED_W-1:0] pred;
  logic signed [15:0]                 scaled;
  logic signed [15:0]                 shifted;
  logic signed [dafd_pkg::HIST_W-1:0] hist_nxt;
  logic signed [17:0]                 pcm_wide;

  assign q_pop = q_valid && (!valid_r || out_ch.ready);

  always_comb begin
    c1 = signed'({1'b0, dafd_pkg::coef_first(q_data.coef_idx)});
    c2 = signed'({1'b0, dafd_pkg::coef_second(q_data.coef_idx)});
    p1 = hist1_r * c1;
    p2 = hist2_r * c2;
    acc = p1 - p2 + dafd_pkg::ROUND_HALF;
    pred_full = acc >>> 6;
    // clamp prediction to 22 bits
    if (pred_full > dafd_pkg::PRED_MAX) begin
      pred = dafd_pkg::PRED_W'(dafd_pkg::PRED_MAX);
    end else if (pred_full < dafd_pkg::PRED_MIN) begin
      pred = dafd_pkg::PRED_W'(dafd_pkg::PRED_MIN);
    end else begin
      pred = pred_full[dafd_pkg::PRED_W-1:0];
    end
    scaled   = {q_data.nibble, 12'b0};
    shifted  = scaled >>> q_data.shift;
    hist_nxt = signed'({shifted, 6'b0}) + pred;
    pcm_wide = hist_nxt[dafd_pkg::HIST_W-1:6];
    if (pcm_wide > dafd_pkg::PCM_MAX) begin
      pcm_nxt = dafd_pkg::PCM_W'(dafd_pkg::PCM_MAX);
    end else if (pcm_wide < dafd_pkg::PCM_MIN) begin
      pcm_nxt = dafd_pkg::PCM_W'(dafd_pkg::PCM_MIN);
    end else begin
      pcm_nxt = pcm_wide[dafd_pkg::PCM_W-1:0];
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.pcm_sample = pcm_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pcm_r <= pcm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hist1_r <= '0;
      hist2_r <= '0;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        hist2_r <= hist1_r;
        hist1_r <= hist_nxt;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/dtk_adpcm_frame_decoder.sv =====
// a sample byte accepted on in_ch is first written into the request queue, then popped by
// the back end into the output register that drives out_ch
// throughput: one byte per cycle while the queue is not full; header bytes give no result,
// sample bytes one each, set by the predictor and history update in the back end
// a four-entry request queue lets input run on while the output stalls
// reset (synchronous, rst_n low): histories, header fields, byte position and channel cleared
module dtk_adpcm_frame_decoder (
  input  logic         clk,
  input  logic         rst_n,
  dafd_byte_if.sink    in_ch,
  dafd_cfg_if.sink     cfg_ch,
  dafd_pcm_if.source   out_ch
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  dafd_pkg::sample_req_t q_in;
  dafd_pkg::sample_req_t q_head;

  dafd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  dafd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  dafd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
